>>> rtl/core/racc_pkg.sv
// Shared types, codes and constants of the register ALU with condition codes.
package racc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned FlagW   = 5;
  localparam int unsigned QDepth  = 2;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagX = 4;

  localparam logic [DataW-1:0] KeepByteMask = 32'hFFFF_FF00;
  localparam logic [DataW-1:0] KeepWordMask = 32'hFFFF_0000;

  typedef enum logic [2:0] {
    OP_MOVE  = 3'd0,
    OP_MOVEQ = 3'd1,
    OP_AND   = 3'd2,
    OP_OR    = 3'd3,
    OP_ADD   = 3'd4,
    OP_SUB   = 3'd5,
    OP_CMP   = 3'd6,
    OP_TEST  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_e;

  typedef enum logic [3:0] {
    CC_T  = 4'd0,
    CC_F  = 4'd1,
    CC_HI = 4'd2,
    CC_LS = 4'd3,
    CC_CC = 4'd4,
    CC_CS = 4'd5,
    CC_NE = 4'd6,
    CC_EQ = 4'd7,
    CC_VC = 4'd8,
    CC_VS = 4'd9,
    CC_PL = 4'd10,
    CC_MI = 4'd11,
    CC_GE = 4'd12,
    CC_LT = 4'd13,
    CC_GT = 4'd14,
    CC_LE = 4'd15
  } cond_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         operand_size;
    logic [RegIdxW-1:0] source_register;
    logic [RegIdxW-1:0] destination_register;
    logic [DataW-1:0]   immediate;
    logic [3:0]         condition_code;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic [FlagW-1:0] flags;
    logic             branch_taken;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    size_e              size;
    logic               is_arith;
    logic               is_sub;
    logic               wr_en;
    logic               set_x;
    logic [RegIdxW-1:0] src;
    logic [RegIdxW-1:0] dst;
    logic [DataW-1:0]   imm;
    cond_e              cc;
  } dec_t;

endpackage

>>> rtl/core/racc_front.sv
// Front end: decodes an input item into an execution class for the queue.
module racc_front (
  input  racc_pkg::in_item_t item_i,
  output racc_pkg::dec_t     dec_o
);
  import racc_pkg::*;

  op_e op;

  assign op = op_e'(item_i.opcode);

  always_comb begin
    dec_o          = '0;
    dec_o.op       = op;
    dec_o.src      = item_i.source_register;
    dec_o.dst      = item_i.destination_register;
    dec_o.imm      = item_i.immediate;
    dec_o.cc       = cond_e'(item_i.condition_code);
    dec_o.is_arith = (op == OP_ADD) || (op == OP_SUB) || (op == OP_CMP);
    dec_o.is_sub   = (op == OP_SUB) || (op == OP_CMP);
    dec_o.wr_en    = (op != OP_CMP) && (op != OP_TEST);
    dec_o.set_x    = (op == OP_ADD) || (op == OP_SUB);
    case (item_i.operand_size)
      SZ_BYTE: dec_o.size = SZ_BYTE;
      SZ_WORD: dec_o.size = SZ_WORD;
      default: dec_o.size = SZ_LONG;
    endcase
    if (op == OP_MOVEQ) begin
      dec_o.size = SZ_LONG;
    end
  end

endmodule

>>> rtl/core/racc_queue.sv
// Short queue of decoded items between the front end and the execution unit.
module racc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  racc_pkg::dec_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output racc_pkg::dec_t pop_data_o
);
  import racc_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  dec_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(QDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/racc_back.sv
// Execution unit: register file, condition flags, ALU and output register.
module racc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              dec_valid_i,
  input  racc_pkg::dec_t    dec_i,
  output logic              dec_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output racc_pkg::out_item_t out_item_o
);
  import racc_pkg::*;

  logic [DataW-1:0] rf_q [NumRegs];
  logic [FlagW-1:0] flags_q, flags_d;
  logic             out_valid_q;
  out_item_t        out_item_q;

  logic [DataW-1:0] sv, dv, m, s, d, r, merged, result;
  logic [DataW-1:0] sum, diff;
  logic             sgn_r, sgn_d, sgn_s, zero, cbit, vbit, taken;
  logic             fc, fv, fz, fn;

  assign dec_pop_o = dec_valid_i && (!out_valid_q || !out_stall_i);

  assign sv = rf_q[dec_i.src];
  assign dv = rf_q[dec_i.dst];

  always_comb begin
    case (dec_i.size)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
  end

  assign s    = sv & m;
  assign d    = dv & m;
  assign sum  = (d + s) & m;
  assign diff = (d - s) & m;

  always_comb begin
    case (dec_i.op)
      OP_MOVE:  r = sv & m;
      OP_MOVEQ: r = dec_i.imm;
      OP_AND:   r = (dv & sv) & m;
      OP_OR:    r = (dv | sv) & m;
      OP_ADD:   r = sum;
      default:  r = diff;
    endcase
  end

  always_comb begin
    case (dec_i.size)
      SZ_BYTE: begin
        sgn_r  = r[7];
        sgn_d  = d[7];
        sgn_s  = s[7];
        merged = (dv & KeepByteMask) | r;
      end
      SZ_WORD: begin
        sgn_r  = r[15];
        sgn_d  = d[15];
        sgn_s  = s[15];
        merged = (dv & KeepWordMask) | r;
      end
      default: begin
        sgn_r  = r[DataW-1];
        sgn_d  = d[DataW-1];
        sgn_s  = s[DataW-1];
        merged = r;
      end
    endcase
  end

  assign zero = (r == '0);

  always_comb begin
    if (dec_i.is_sub) begin
      cbit = (!sgn_d && sgn_s) || (!(sgn_d ^ sgn_s) && sgn_r);
      vbit = (sgn_d ^ sgn_s) && (sgn_r ^ sgn_d);
    end else begin
      cbit = (sgn_d && sgn_s) || ((sgn_d || sgn_s) && !sgn_r);
      vbit = !(sgn_d ^ sgn_s) && (sgn_r ^ sgn_d);
    end
  end

  assign fc = flags_q[FlagC];
  assign fv = flags_q[FlagV];
  assign fz = flags_q[FlagZ];
  assign fn = flags_q[FlagN];

  always_comb begin
    case (dec_i.cc)
      CC_T:    taken = 1'b1;
      CC_F:    taken = 1'b0;
      CC_HI:   taken = !(fc || fz);
      CC_LS:   taken = fc || fz;
      CC_CC:   taken = !fc;
      CC_CS:   taken = fc;
      CC_NE:   taken = !fz;
      CC_EQ:   taken = fz;
      CC_VC:   taken = !fv;
      CC_VS:   taken = fv;
      CC_PL:   taken = !fn;
      CC_MI:   taken = fn;
      CC_GE:   taken = !(fn ^ fv);
      CC_LT:   taken = fn ^ fv;
      CC_GT:   taken = !((fn ^ fv) || fz);
      default: taken = (fn ^ fv) || fz;
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (dec_i.op != OP_TEST) begin
      flags_d[FlagN] = sgn_r;
      flags_d[FlagZ] = zero;
      flags_d[FlagV] = dec_i.is_arith && vbit;
      flags_d[FlagC] = dec_i.is_arith && cbit;
      if (dec_i.set_x) begin
        flags_d[FlagX] = cbit;
      end
    end
  end

  assign result = dec_i.wr_en ? merged : dv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (dec_pop_o) begin
        flags_q <= flags_d;
        if (dec_i.wr_en) begin
          rf_q[dec_i.dst] <= merged;
        end
      end
      if (dec_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_pop_o) begin
      out_item_q.result_value <= result;
      out_item_q.flags        <= flags_d;
      out_item_q.branch_taken <= (dec_i.op == OP_TEST) && taken;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_test_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_pop_o && (dec_i.op == OP_TEST) |=> $stable(flags_q))
    else $error("test changed the flags");

  a_taken_only_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_pop_o && (dec_i.op != OP_TEST) |=> !out_item_q.branch_taken)
    else $error("branch taken on a non-test item");

  a_x_kept_unless_addsub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_pop_o && !dec_i.set_x |=> flags_q[FlagX] == $past(flags_q[FlagX]))
    else $error("X changed outside add or sub");

  a_out_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_pop_o |=> out_item_q.flags == flags_q)
    else $error("reported flags differ from flag register");
`endif

endmodule

>>> rtl/core/reg_alu_condition_codes.sv
// Top level of the register ALU with condition codes.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_item_i  (racc_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (racc_pkg::out_item_t)
//
// One item per cycle sustained while the output is not stalled; an accepted item is written
// into the queue, then executed from the queue into the output register.
// The register file read, ALU and flag update close in the execution stage.
// Reset clears all eight data registers and the flags at once; no sweep is needed.
// Input stalls only when the two-entry queue is full; output stall holds the result register.
module reg_alu_condition_codes (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  racc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output racc_pkg::out_item_t out_item_o
);
  import racc_pkg::*;

  dec_t dec_front;
  dec_t dec_queue;
  logic q_full, q_empty, q_push, q_pop;

  racc_front u_front (
    .item_i (in_item_i),
    .dec_o  (dec_front)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  racc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (dec_front),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (dec_queue)
  );

  racc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (!q_empty),
    .dec_i       (dec_queue),
    .dec_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> test/reg_alu_condition_codes_test.sv
// Self-checking testbench for the register ALU with condition codes.
module reg_alu_condition_codes_test;
  timeunit 1ns;
  timeprecision 1ps;

  import racc_pkg::*;

  localparam int unsigned ResetCycles = 9;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldAt      = 1000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainAt     = 850;
  localparam int unsigned MaxReports  = 10;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  reg_alu_condition_codes dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  stim_t       pending_q[$];
  out_item_t   expected_q[$];
  logic [31:0] reg_file[NumRegs];
  logic [4:0]  ccr;

  int unsigned n_offered   = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_results   = 0;
  int unsigned n_mismatch  = 0;
  int unsigned n_taken     = 0;
  int unsigned n_in_stalls = 0;
  int unsigned cycles      = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_seen     = 0;
  bit          hold_done   = 1'b0;

  function automatic logic [4:0] nz_flags(logic [31:0] v, logic [31:0] m, logic [31:0] sb);
    logic [4:0] f;
    f = '0;
    f[FlagZ] = ((v & m) == 32'd0);
    f[FlagN] = ((v & sb) != 32'd0);
    return f;
  endfunction

  function automatic logic cond_holds(cond_e cc, logic [4:0] f);
    logic c, v, z, n;
    c = f[FlagC];
    v = f[FlagV];
    z = f[FlagZ];
    n = f[FlagN];
    case (cc)
      CC_T:    return 1'b1;
      CC_F:    return 1'b0;
      CC_HI:   return !(c | z);
      CC_LS:   return c | z;
      CC_CC:   return !c;
      CC_CS:   return c;
      CC_NE:   return !z;
      CC_EQ:   return z;
      CC_VC:   return !v;
      CC_VS:   return v;
      CC_PL:   return !n;
      CC_MI:   return n;
      CC_GE:   return !(n ^ v);
      CC_LT:   return n ^ v;
      CC_GT:   return !((n ^ v) | z);
      default: return (n ^ v) | z;
    endcase
  endfunction

  function automatic out_item_t execute_insn(in_item_t it);
    logic [31:0] m, sb, sv, dv, s, d, r, cbit, vbit;
    logic [4:0]  f, keep_x;
    logic        taken;
    out_item_t   o;
    case (it.operand_size)
      SZ_BYTE: begin
        m  = 32'h0000_00FF;
        sb = 32'h0000_0080;
      end
      SZ_WORD: begin
        m  = 32'h0000_FFFF;
        sb = 32'h0000_8000;
      end
      default: begin
        m  = 32'hFFFF_FFFF;
        sb = 32'h8000_0000;
      end
    endcase
    sv = reg_file[it.source_register];
    dv = reg_file[it.destination_register];
    keep_x = '0;
    keep_x[FlagX] = ccr[FlagX];
    taken = 1'b0;
    case (it.opcode)
      OP_MOVE: begin
        r = sv & m;
        reg_file[it.destination_register] = (dv & ~m) | r;
        ccr = keep_x | nz_flags(r, m, sb);
      end
      OP_MOVEQ: begin
        reg_file[it.destination_register] = it.immediate;
        ccr = keep_x | nz_flags(it.immediate, 32'hFFFF_FFFF, 32'h8000_0000);
      end
      OP_AND, OP_OR: begin
        r = ((it.opcode == OP_AND) ? (dv & sv) : (dv | sv)) & m;
        reg_file[it.destination_register] = (dv & ~m) | r;
        ccr = keep_x | nz_flags(r, m, sb);
      end
      OP_ADD, OP_SUB, OP_CMP: begin
        s = sv & m;
        d = dv & m;
        if (it.opcode == OP_ADD) begin
          r    = (d + s) & m;
          cbit = ((d & s) | ((d | s) & ~r)) & sb;
          vbit = (~(d ^ s) & (r ^ d)) & sb;
        end else begin
          r    = (d - s) & m;
          cbit = ((~d & s) | (~(d ^ s) & r)) & sb;
          vbit = ((d ^ s) & (r ^ d)) & sb;
        end
        f = nz_flags(r, m, sb);
        f[FlagC] = (cbit != 32'd0);
        f[FlagV] = (vbit != 32'd0);
        if (it.opcode == OP_CMP) begin
          ccr = keep_x | f;
        end else begin
          f[FlagX] = f[FlagC];
          ccr = f;
          reg_file[it.destination_register] = (dv & ~m) | r;
        end
      end
      default: begin
        taken = cond_holds(cond_e'(it.condition_code), ccr);
      end
    endcase
    o.result_value = reg_file[it.destination_register];
    o.flags        = ccr;
    o.branch_taken = taken;
    return o;
  endfunction

  function automatic void push_insn(op_e op, logic [1:0] sz, int unsigned src,
                                    int unsigned dst, logic [31:0] imm, cond_e cc);
    stim_t st;
    st.item.opcode               = op;
    st.item.operand_size         = sz;
    st.item.source_register      = src[RegIdxW-1:0];
    st.item.destination_register = dst[RegIdxW-1:0];
    st.item.immediate            = imm;
    st.item.condition_code       = cc;
    st.gap   = $urandom_range(0, 3);
    st.drain = 1'b0;
    pending_q.push_back(st);
  endfunction

  function automatic in_item_t random_insn();
    in_item_t    it;
    int unsigned pick;
    it.opcode               = 3'($urandom_range(0, 7));
    it.operand_size         = 2'($urandom_range(0, 3));
    it.source_register      = RegIdxW'($urandom_range(0, NumRegs - 1));
    it.destination_register = RegIdxW'($urandom_range(0, NumRegs - 1));
    it.immediate            = $urandom;
    it.condition_code       = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 15);
    if (it.opcode == OP_MOVEQ) begin
      case (pick)
        0: it.immediate = 32'h0000_0000;
        1: it.immediate = 32'h0000_007F;
        2: it.immediate = 32'h0000_0080;
        3: it.immediate = 32'h0000_00FF;
        4: it.immediate = 32'h0000_7FFF;
        5: it.immediate = 32'h0000_8000;
        6: it.immediate = 32'h0000_FFFF;
        7: it.immediate = 32'h7FFF_FFFF;
        8: it.immediate = 32'h8000_0000;
        9: it.immediate = 32'hFFFF_FFFF;
        default: ;
      endcase
    end else if (pick >= 13) begin
      it.source_register = it.destination_register;
    end
    return it;
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && n_accepted != n_offered)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && expected_q.size() != 0)) begin
        in_item_i  <= pending_q[0].item;
        in_valid_i <= 1'b1;
        gap_left = pending_q[0].gap;
        void'(pending_q.pop_front());
        n_offered++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_results >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (n_results != rx_seen) begin
        rx_seen    = n_results;
        stall_left = ((n_results / 150) % 3 == 1) ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 expected_q.size());
        $display("tb: failure");
        $finish;
      end else begin
        if (in_valid_i && in_stall_o) n_in_stalls++;
        if (in_valid_i && !in_stall_o) begin
          expected_q.push_back(execute_insn(in_item_i));
          n_accepted++;
        end
        if (out_valid_o && !out_stall_i) begin
          n_results++;
          if (expected_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MaxReports)
              $display("result %0d arrived with nothing expected: value %h flags %b taken %b",
                       n_results, out_item_o.result_value, out_item_o.flags,
                       out_item_o.branch_taken);
          end else begin
            want = expected_q.pop_front();
            if (want.branch_taken) n_taken++;
            if (out_item_o.result_value !== want.result_value ||
                out_item_o.flags !== want.flags ||
                out_item_o.branch_taken !== want.branch_taken) begin
              n_mismatch++;
              if (n_mismatch <= MaxReports)
                $display("result %0d: value %h/%h flags %b/%b taken %b/%b (got/exp)",
                         n_results, out_item_o.result_value, want.result_value,
                         out_item_o.flags, want.flags, out_item_o.branch_taken,
                         want.branch_taken);
            end
          end
        end
      end
    end
  end

  initial begin
    stim_t st;
    for (int i = 0; i < NumRegs; i++) reg_file[i] = '0;
    ccr = '0;

    push_insn(OP_MOVEQ, SZ_BYTE, 0, 0, 32'h8000_0000, CC_T);
    push_insn(OP_MOVEQ, SZ_WORD, 0, 1, 32'hFFFF_FFFF, CC_F);
    push_insn(OP_MOVEQ, SZ_LONG, 0, 2, 32'h0000_0000, CC_HI);
    push_insn(OP_MOVEQ, SZ_LONG, 0, 3, 32'h7FFF_FFFF, CC_LS);
    push_insn(OP_MOVEQ, SZ_LONG, 0, 4, 32'h0000_0001, CC_CC);
    push_insn(OP_MOVEQ, SZ_LONG, 0, 5, 32'h0000_0080, CC_CS);
    push_insn(OP_ADD,   SZ_LONG, 4, 3, $urandom, CC_NE);
    push_insn(OP_ADD,   SZ_BYTE, 4, 1, $urandom, CC_EQ);
    push_insn(OP_TEST,  SZ_LONG, 0, 1, $urandom, CC_CS);
    push_insn(OP_TEST,  SZ_LONG, 0, 1, $urandom, CC_F);
    push_insn(OP_SUB,   SZ_BYTE, 4, 2, $urandom, CC_VC);
    push_insn(OP_TEST,  SZ_LONG, 0, 2, $urandom, CC_LT);
    push_insn(OP_CMP,   SZ_WORD, 0, 0, $urandom, CC_VS);
    push_insn(OP_TEST,  SZ_LONG, 0, 0, $urandom, CC_EQ);
    push_insn(OP_AND,   SZ_WORD, 5, 1, $urandom, CC_PL);
    push_insn(OP_OR,    SZ_BYTE, 0, 5, $urandom, CC_MI);
    push_insn(OP_MOVE,  SZ_BYTE, 1, 6, $urandom, CC_GE);
    push_insn(OP_MOVE,  2'd3,    0, 7, $urandom, CC_LT);
    push_insn(OP_SUB,   SZ_LONG, 0, 4, $urandom, CC_GT);
    push_insn(OP_TEST,  SZ_LONG, 0, 4, $urandom, CC_VS);
    push_insn(OP_TEST,  SZ_LONG, 0, 4, $urandom, CC_GT);
    push_insn(OP_TEST,  SZ_LONG, 0, 4, $urandom, CC_HI);
    push_insn(OP_TEST,  SZ_LONG, 0, 4, $urandom, CC_T);
    push_insn(OP_ADD,   SZ_WORD, 6, 6, $urandom, CC_LE);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      st.item  = random_insn();
      st.gap   = ((i / 200) % 3 == 2) ? 0 : $urandom_range(0, 3);
      st.drain = (i == 0 || i == DrainAt);
      pending_q.push_back(st);
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || n_accepted != n_offered || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d instructions, %0d results, %0d branch tests taken",
             n_accepted, n_results, n_taken);
    $display("summary: %0d input stall cycles, %0d mismatches", n_in_stalls, n_mismatch);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
